// File: hdl/piecewise_linear_calibration_assert.svh
// ----------------------------------------------------------------------------
// piecewise linear calibration assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CALIBRATION_ASSERT_SVH
`define PIECEWISE_LINEAR_CALIBRATION_ASSERT_SVH

// same-cycle implication
`define PLC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg
// shared constants, types and reset tables of the calibration block
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int NUM_POINTS = 5;
	localparam int PT_IDX_W   = $clog2(NUM_POINTS);
	localparam int IDX_IN_W   = 3;
	localparam int RAW_W      = 16;
	localparam int POS_W      = 16;
	localparam int MASK_OUT_W = 5;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	localparam int MD_W     = 16;
	localparam int MD_CNT_W = $clog2(MD_W);

	localparam logic [PT_IDX_W-1:0]   LAST_IDX  = PT_IDX_W'(NUM_POINTS - 1);
	localparam logic [NUM_POINTS-1:0] FULL_MASK = {NUM_POINTS{1'b1}};

	typedef struct packed {
		logic                    en;
		logic [PT_IDX_W-1:0]     idx;
		logic [RAW_W-1:0]        raw;
		logic signed [POS_W-1:0] pos;
	} plc_wr_t;

	typedef struct packed {
		logic            start;
		logic [MD_W-1:0] mcand;
		logic [MD_W-1:0] mplier;
		logic [MD_W-1:0] divisor;
	} plc_md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} plc_md_stat_t;

	function automatic logic [RAW_W-1:0] reset_raw(int n);
		return RAW_W'(50 + 50 * n);
	endfunction

	function automatic logic [POS_W-1:0] reset_pos(int n);
		return POS_W'(1000 * n);
	endfunction

endpackage

// File: hdl/piecewise_linear_calibration.sv
`timescale 1ns / 1ps
// a write item goes to the done state, which fills the output register once the
// output side is free; a convert item goes to done from clamp when clamped, else it
//   scans, then passes setup and, unless the segment is flat, the multiply-divide,
//   or the nearer-endpoint state when no segment holds the reading
// one item at a time: the next item is taken once the result is registered
// reset: arst_n clears control, mask and ready flag, and loads the default points
// ----------------------------------------------------------------------------
// piecewise_linear_calibration
// five-point sensor calibration with sequential segment search and
// bit-serial interpolation
// ----------------------------------------------------------------------------
`include "piecewise_linear_calibration_assert.svh"

module piecewise_linear_calibration import plc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // point_index, raw_reading, true_position, pad
	input  logic                  s_tuser,  // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // position, accepted, ready_res, received_mask, pad
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CLAMP  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_SETUP  = 3'd3;
	localparam logic [2:0] ST_MULDIV = 3'd4;
	localparam logic [2:0] ST_NEAR   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	localparam logic KIND_WRITE = 1'b0;

	logic [2:0]              state_q;
	logic [RAW_W-1:0]        x_q;
	logic [RAW_W-1:0]        ra_q;
	logic signed [POS_W-1:0] pa_q;
	logic [RAW_W-1:0]        rb_q;
	logic signed [POS_W-1:0] pb_q;
	logic [PT_IDX_W-1:0]     idx_q;
	logic                    neg_q;
	logic signed [POS_W-1:0] res_pos_q;
	logic                    res_acc_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;

	logic [IDX_IN_W-1:0]     idx_in;
	logic [RAW_W-1:0]        raw_in;
	logic [POS_W-1:0]        pos_in;
	logic                    accept;
	logic                    idx_ok;
	logic                    out_free;

	plc_wr_t                 wr;
	plc_md_req_t             md_req;
	plc_md_stat_t            md_stat;
	logic [MD_W-1:0]         md_quot;

	logic [RAW_W-1:0]        rd_raw;
	logic signed [POS_W-1:0] rd_pos;
	logic [RAW_W-1:0]        first_raw;
	logic signed [POS_W-1:0] first_pos;
	logic [RAW_W-1:0]        last_raw;
	logic signed [POS_W-1:0] last_pos;
	logic [NUM_POINTS-1:0]   mask;
	logic                    ready;

	logic                    descending;
	logic                    clamp_first;
	logic                    clamp_last;
	logic                    hit;
	logic [RAW_W:0]          dx_d;
	logic [RAW_W:0]          t_d;
	logic [POS_W:0]          dy_d;
	logic [RAW_W:0]          d0_d;
	logic [RAW_W:0]          dl_d;
	logic [RAW_W-1:0]        d0_mag;
	logic [RAW_W-1:0]        dl_mag;
	logic [MD_W:0]           q_signed;
	logic [POS_W+1:0]        interp_sum;

	assign idx_in   = s_tdata[IDX_IN_W-1:0];
	assign raw_in   = s_tdata[IDX_IN_W+RAW_W-1:IDX_IN_W];
	assign pos_in   = s_tdata[IDX_IN_W+RAW_W+POS_W-1:IDX_IN_W+RAW_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign idx_ok   = ({{(32-IDX_IN_W){1'b0}}, idx_in} < 32'(NUM_POINTS));
	assign out_free = !m_tvalid_q || m_tready;

	assign wr.en  = accept && (s_tuser == KIND_WRITE) && idx_ok;
	assign wr.idx = PT_IDX_W'(idx_in);
	assign wr.raw = raw_in;
	assign wr.pos = pos_in;

	plc_point_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_idx    (idx_q),
		.rd_raw    (rd_raw),
		.rd_pos    (rd_pos),
		.first_raw (first_raw),
		.first_pos (first_pos),
		.last_raw  (last_raw),
		.last_pos  (last_pos),
		.mask      (mask),
		.ready     (ready)
	);

	// end clamping
	assign descending  = (first_raw > last_raw);
	assign clamp_first = descending ? (x_q >= first_raw) : (x_q <= first_raw);
	assign clamp_last  = descending ? (x_q <= last_raw) : (x_q >= last_raw);

	// segment containment, either orientation
	assign hit = ((x_q >= ra_q) && (x_q <= rd_raw)) || ((x_q >= rd_raw) && (x_q <= ra_q));

	// segment deltas and magnitudes
	assign dx_d = {1'b0, rb_q} - {1'b0, ra_q};
	assign t_d  = {1'b0, x_q} - {1'b0, ra_q};
	assign dy_d = {pb_q[POS_W-1], pb_q} - {pa_q[POS_W-1], pa_q};

	assign md_req.start   = (state_q == ST_SETUP) && (dx_d != '0);
	assign md_req.mcand   = dy_d[POS_W] ? MD_W'(-dy_d) : dy_d[MD_W-1:0];
	assign md_req.mplier  = t_d[RAW_W] ? MD_W'(-t_d) : t_d[MD_W-1:0];
	assign md_req.divisor = dx_d[RAW_W] ? MD_W'(-dx_d) : dx_d[MD_W-1:0];

	plc_serial_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.stat   (md_stat),
		.quot   (md_quot)
	);

	assign q_signed   = neg_q ? -{1'b0, md_quot} : {1'b0, md_quot};
	assign interp_sum = {{2{pa_q[POS_W-1]}}, pa_q} + {q_signed[MD_W], q_signed};

	// endpoint distances when no segment holds the reading
	assign d0_d   = {1'b0, x_q} - {1'b0, first_raw};
	assign dl_d   = {1'b0, x_q} - {1'b0, last_raw};
	assign d0_mag = d0_d[RAW_W] ? RAW_W'(-d0_d) : d0_d[RAW_W-1:0];
	assign dl_mag = dl_d[RAW_W] ? RAW_W'(-dl_d) : dl_d[RAW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && !((state_q == ST_DONE) && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser == KIND_WRITE) ? ST_DONE : ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= (clamp_first || clamp_last) ? ST_DONE : ST_SCAN;
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_SETUP;
					end else if (idx_q == LAST_IDX) begin
						state_q <= ST_NEAR;
					end
				end
				ST_SETUP: begin
					state_q <= md_req.start ? ST_MULDIV : ST_DONE;
				end
				ST_MULDIV: begin
					if (md_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_NEAR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q       <= raw_in;
				res_pos_q <= '0;
				res_acc_q <= (s_tuser != KIND_WRITE) || idx_ok;
			end
			ST_CLAMP: begin
				res_pos_q <= clamp_first ? first_pos : last_pos;
				ra_q      <= first_raw;
				pa_q      <= first_pos;
				idx_q     <= PT_IDX_W'(1);
			end
			ST_SCAN: begin
				rb_q <= rd_raw;
				pb_q <= rd_pos;
				if (!hit) begin
					ra_q  <= rd_raw;
					pa_q  <= rd_pos;
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_SETUP: begin
				res_pos_q <= pa_q;
				neg_q     <= t_d[RAW_W] ^ dy_d[POS_W] ^ dx_d[RAW_W];
			end
			ST_MULDIV: begin
				res_pos_q <= interp_sum[POS_W-1:0];
			end
			ST_NEAR: begin
				res_pos_q <= (d0_mag < dl_mag) ? first_pos : last_pos;
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, MASK_OUT_W'(mask), ready, res_acc_q, res_pos_q};
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PLC_ASSERT_IMP(a_ready_full, ready, mask == FULL_MASK, "ready flag set without all points")
	`PLC_ASSERT_NXT(a_mask_keeps, 1'b1, (mask & $past(mask)) == $past(mask), "received mask lost a bit")
	`PLC_ASSERT_IMP(a_done_state, md_stat.done, state_q == ST_MULDIV, "divider finished out of turn")
	`PLC_ASSERT_IMP(a_md_busy, (state_q == ST_MULDIV) && !md_stat.done, md_stat.busy, "divider idle while awaited")
	`PLC_ASSERT_NXT(a_accept_leaves, accept, state_q != ST_IDLE, "accepted item not taken up")

endmodule

// File: hdl/plc_point_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_point_store
// calibration point registers, received mask and ready flag
// ----------------------------------------------------------------------------
module plc_point_store import plc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  plc_wr_t                 wr,
	input  logic [PT_IDX_W-1:0]     rd_idx,
	output logic [RAW_W-1:0]        rd_raw,
	output logic signed [POS_W-1:0] rd_pos,
	output logic [RAW_W-1:0]        first_raw,
	output logic signed [POS_W-1:0] first_pos,
	output logic [RAW_W-1:0]        last_raw,
	output logic signed [POS_W-1:0] last_pos,
	output logic [NUM_POINTS-1:0]   mask,
	output logic                    ready
);

	logic [RAW_W-1:0]        raw_q  [NUM_POINTS];
	logic signed [POS_W-1:0] pos_q  [NUM_POINTS];
	logic [NUM_POINTS-1:0]   mask_q;
	logic                    ready_q;
	logic [NUM_POINTS-1:0]   mask_next;

	always_comb begin
		mask_next = mask_q;
		if (wr.en) begin
			mask_next[wr.idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				raw_q[i] <= reset_raw(i);
				pos_q[i] <= reset_pos(i);
			end
			mask_q  <= '0;
			ready_q <= 1'b0;
		end else if (wr.en) begin
			raw_q[wr.idx] <= wr.raw;
			pos_q[wr.idx] <= wr.pos;
			mask_q        <= mask_next;
			if (mask_next == FULL_MASK) begin
				ready_q <= 1'b1;
			end
		end
	end

	assign rd_raw    = raw_q[rd_idx];
	assign rd_pos    = pos_q[rd_idx];
	assign first_raw = raw_q[0];
	assign first_pos = pos_q[0];
	assign last_raw  = raw_q[LAST_IDX];
	assign last_pos  = pos_q[LAST_IDX];
	assign mask      = mask_q;
	assign ready     = ready_q;

endmodule

// File: hdl/plc_serial_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_serial_muldiv
// bit-serial unsigned multiply then restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
module plc_serial_muldiv import plc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  plc_md_req_t     req,
	output plc_md_stat_t    stat,
	output logic [MD_W-1:0] quot
);

	logic                  busy_q;
	logic                  done_q;
	logic                  div_phase_q;
	logic [MD_CNT_W-1:0]   cnt_q;
	logic [2*MD_W-1:0]     acc_q;
	logic [MD_W-1:0]       mcand_q;
	logic [MD_W-1:0]       divisor_q;

	logic [MD_W:0]         mul_hi;
	logic [MD_W:0]         trial;
	logic [MD_W:0]         trial_sub;
	logic                  trial_ge;
	logic [MD_W-1:0]       rem_new;
	logic                  last_step;

	localparam logic [MD_CNT_W-1:0] CNT_LAST = MD_CNT_W'(MD_W - 1);

	// shift-add multiply step
	assign mul_hi = {1'b0, acc_q[2*MD_W-1:MD_W]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

	// restoring divide step, remainder starts below the divisor
	assign trial     = {acc_q[2*MD_W-1:MD_W], acc_q[MD_W-1]};
	assign trial_sub = trial - {1'b0, divisor_q};
	assign trial_ge  = (trial >= {1'b0, divisor_q});
	assign rem_new   = trial_ge ? trial_sub[MD_W-1:0] : trial[MD_W-1:0];
	assign last_step = (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			div_phase_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q      <= 1'b1;
				div_phase_q <= 1'b0;
				cnt_q       <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					cnt_q <= '0;
					if (div_phase_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						div_phase_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q     <= {{MD_W{1'b0}}, req.mplier};
			mcand_q   <= req.mcand;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (div_phase_q) begin
				acc_q <= {rem_new, acc_q[MD_W-2:0], trial_ge};
			end else begin
				acc_q <= {mul_hi, acc_q[MD_W-1:1]};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = acc_q[MD_W-1:0];

endmodule

// File: test/piecewise_linear_calibration_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_test
// streams point writes and reading conversions through the calibration
// block, predicts every result with a local copy of the point table and
// compares each output item field by field, with bursty input and a
// stalling output side
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_test;
	import plc_pkg::*;

	typedef enum logic {
		KIND_WRITE   = 1'b0,
		KIND_CONVERT = 1'b1
	} item_kind_t;

	typedef struct {
		item_kind_t               kind;
		logic [IDX_IN_W-1:0]      idx;
		logic [RAW_W-1:0]         raw;
		logic signed [POS_W-1:0]  tpos;
	} sensor_item_t;

	typedef struct {
		logic signed [POS_W-1:0]  position;
		logic                     accepted;
		logic                     ready;
		logic [MASK_OUT_W-1:0]    mask;
	} calib_out_t;

	localparam int TOTAL_ITEMS = 1850;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	sensor_item_t sensor_items[$];
	calib_out_t   calib_outputs[$];

	// local copy of the calibration table
	logic [RAW_W-1:0]        cal_raw [NUM_POINTS];
	logic signed [POS_W-1:0] cal_pos [NUM_POINTS];
	logic [MASK_OUT_W-1:0]   cal_mask;
	logic                    cal_ready;

	int errors;
	int n_writes;
	int n_rejected;
	int n_converts;
	int n_checked;

	int burst_left;
	int gap_left;
	int rx_mode;
	logic [15:0] rx_pattern;
	logic [15:0] rx_tick;

	piecewise_linear_calibration u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic logic signed [POS_W-1:0] map_reading(input logic [RAW_W-1:0] x);
		longint xv, r0, rl, ra, rb, lo, hi, dx, dy, q;
		int n;
		xv = x;
		r0 = cal_raw[0];
		rl = cal_raw[NUM_POINTS-1];
		if (r0 > rl) begin
			if (xv >= r0) return cal_pos[0];
			if (xv <= rl) return cal_pos[NUM_POINTS-1];
		end else begin
			if (xv <= r0) return cal_pos[0];
			if (xv >= rl) return cal_pos[NUM_POINTS-1];
		end
		for (n = 0; n < NUM_POINTS - 1; n++) begin
			ra = cal_raw[n];
			rb = cal_raw[n+1];
			lo = (ra < rb) ? ra : rb;
			hi = (ra < rb) ? rb : ra;
			if (xv >= lo && xv <= hi) begin
				dx = rb - ra;
				dy = longint'(cal_pos[n+1]) - longint'(cal_pos[n]);
				if (dx == 0) return cal_pos[n];
				// signed division truncates toward zero
				q = longint'(cal_pos[n]) + ((xv - ra) * dy) / dx;
				return POS_W'(q);
			end
		end
		// no segment holds the reading: strictly nearer endpoint, tie to the last
		if (((xv > r0) ? xv - r0 : r0 - xv) < ((xv > rl) ? xv - rl : rl - xv))
			return cal_pos[0];
		return cal_pos[NUM_POINTS-1];
	endfunction

	function automatic calib_out_t calib_step(input sensor_item_t it);
		calib_out_t res;
		res.position = '0;
		res.accepted = 1'b1;
		if (it.kind == KIND_WRITE) begin
			if (it.idx < NUM_POINTS) begin
				cal_raw[it.idx] = it.raw;
				cal_pos[it.idx] = it.tpos;
				cal_mask[it.idx] = 1'b1;
				if (cal_mask == FULL_MASK) cal_ready = 1'b1;
				n_writes++;
			end else begin
				res.accepted = 1'b0;
				n_rejected++;
			end
		end else begin
			res.position = map_reading(it.raw);
			n_converts++;
		end
		res.ready = cal_ready;
		res.mask  = cal_mask;
		return res;
	endfunction

	task automatic add_item(input item_kind_t kind, input int idx, input int raw, input int tpos);
		sensor_item_t it;
		it.kind = kind;
		it.idx  = IDX_IN_W'(idx);
		it.raw  = RAW_W'(raw);
		it.tpos = POS_W'(tpos);
		sensor_items.push_back(it);
	endtask

	task automatic add_convert(input int raw);
		add_item(KIND_CONVERT, $urandom_range(0, 7), raw, $urandom_range(0, 65535));
	endtask

	function automatic int rand_position(input int style);
		case (style)
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 2000) - 1000;
			default: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return $urandom_range(0, 65535) - 32768;
				endcase
			end
		endcase
	endfunction

	// one full table load followed by conversions against it
	task automatic add_curve_set();
		int r [NUM_POINTS];
		int p [NUM_POINTS];
		int order [NUM_POINTS];
		int shape, style, step, tmp, j, k, nconv, lo_r, hi_r, x;
		shape = $urandom_range(0, 9);
		style = $urandom_range(0, 2);
		r[0] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30000);
		for (k = 1; k < NUM_POINTS; k++) begin
			step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12000);
			r[k] = (r[k-1] + step > 65535) ? 65535 : r[k-1] + step;
		end
		if ($urandom_range(0, 4) == 0) r[NUM_POINTS-1] = 65535;
		if (shape < 4) begin
			for (k = 0; k < NUM_POINTS / 2; k++) begin
				tmp = r[k];
				r[k] = r[NUM_POINTS-1-k];
				r[NUM_POINTS-1-k] = tmp;
			end
		end else if (shape == 9) begin
			for (k = 0; k < NUM_POINTS; k++) r[k] = $urandom_range(0, 65535);
		end
		for (k = 0; k < NUM_POINTS; k++) begin
			p[k] = rand_position(style);
			order[k] = k;
		end
		for (k = NUM_POINTS - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (k = 0; k < NUM_POINTS; k++) begin
			if ($urandom_range(0, 15) == 0)
				add_item(KIND_WRITE, $urandom_range(NUM_POINTS, 7), $urandom_range(0, 65535),
					rand_position(0));
			add_item(KIND_WRITE, order[k], r[order[k]], p[order[k]]);
		end
		lo_r = (r[0] < r[NUM_POINTS-1]) ? r[0] : r[NUM_POINTS-1];
		hi_r = (r[0] < r[NUM_POINTS-1]) ? r[NUM_POINTS-1] : r[0];
		nconv = $urandom_range(2, 10);
		for (k = 0; k < nconv; k++) begin
			case ($urandom_range(0, 5))
				0, 1, 2: x = $urandom_range(lo_r, hi_r);
				3: x = r[$urandom_range(0, NUM_POINTS - 1)];
				4: x = $urandom_range(0, 1) ? $urandom_range(0, lo_r) : $urandom_range(hi_r, 65535);
				default: x = $urandom_range(0, 65535);
			endcase
			add_convert(x);
		end
	endtask

	// stimulus and run control
	initial begin
		int k;
		add_convert(0);
		add_convert(125);
		add_convert(65535);
		add_item(KIND_WRITE, 5, 1234, -5);
		add_item(KIND_WRITE, 7, 65535, 32767);
		// descending full-span curve with a flat segment
		add_item(KIND_WRITE, 4, 0, 32767);
		add_item(KIND_WRITE, 0, 65535, -32768);
		add_item(KIND_WRITE, 2, 49152, 500);
		add_item(KIND_WRITE, 1, 49152, -100);
		add_item(KIND_WRITE, 3, 16384, 20000);
		add_convert(65535);
		add_convert(0);
		add_convert(49152);
		add_convert(30000);
		add_convert(40000);
		add_convert(1);
		add_item(KIND_WRITE, 6, 4321, -32768);
		add_item(KIND_WRITE, 2, 32768, -1);
		add_convert(32768);
		add_convert(50000);
		while (sensor_items.size() < TOTAL_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: add_curve_set();
				6, 7: begin
					for (k = 0; k < 4; k++) add_convert($urandom_range(0, 65535));
				end
				8: add_item(KIND_WRITE, $urandom_range(0, 7), $urandom_range(0, 65535),
					rand_position(0));
				default: begin
					for (k = 0; k < 2; k++)
						add_item(KIND_WRITE, $urandom_range(0, NUM_POINTS - 1),
							$urandom_range(0, 65535), rand_position(1));
					add_convert($urandom_range(0, 65535));
				end
			endcase
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (sensor_items.size() != 0 || s_tvalid) @(posedge clk);
		while (calib_outputs.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("run covered %0d point writes, %0d rejected writes and %0d conversions",
			n_writes, n_rejected, n_converts);
		$display("%0d output items checked, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10ms;
		$display("timeout with %0d items unsent and %0d results outstanding",
			sensor_items.size(), calib_outputs.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// driver: bursts of items separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		sensor_item_t it;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= 1'b0;
			burst_left <= 8;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (sensor_items.size() != 0) begin
				it = sensor_items.pop_front();
				s_tuser  <= it.kind;
				s_tdata  <= {{(IN_DATA_W - IDX_IN_W - RAW_W - POS_W){1'b0}}, it.tpos, it.raw, it.idx};
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side: always ready, a rotating mask, or mostly stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			rx_tick    <= '0;
			rx_mode    <= 0;
			rx_pattern <= 16'hffff;
		end else begin
			rx_tick <= rx_tick + 1'b1;
			if (rx_tick[7:0] == 8'd0) begin
				rx_mode    <= $urandom_range(0, 2);
				rx_pattern <= 16'($urandom) | 16'h0101;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= rx_pattern[rx_tick[3:0]];
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// prediction on every accepted input item
	always @(posedge clk or negedge arst_n) begin
		sensor_item_t it;
		int n;
		if (!arst_n) begin
			for (n = 0; n < NUM_POINTS; n++) begin
				cal_raw[n] = RAW_W'(50 + 50 * n);
				cal_pos[n] = POS_W'(1000 * n);
			end
			cal_mask  = '0;
			cal_ready = 1'b0;
		end else if (s_tvalid && s_tready) begin
			it.kind = item_kind_t'(s_tuser);
			it.idx  = s_tdata[IDX_IN_W-1:0];
			it.raw  = s_tdata[IDX_IN_W +: RAW_W];
			it.tpos = s_tdata[IDX_IN_W + RAW_W +: POS_W];
			calib_outputs.push_back(calib_step(it));
		end
	end

	// monitor: compare each output item with the oldest prediction
	always @(posedge clk) begin
		calib_out_t exp_out;
		calib_out_t act;
		if (arst_n && m_tvalid && m_tready) begin
			act.position = m_tdata[POS_W-1:0];
			act.accepted = m_tdata[POS_W];
			act.ready    = m_tdata[POS_W+1];
			act.mask     = m_tdata[POS_W+2 +: MASK_OUT_W];
			if (calib_outputs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t unexpected output item pos %0d acc %0b rdy %0b mask %05b",
						$realtime, act.position, act.accepted, act.ready, act.mask);
			end else begin
				exp_out = calib_outputs.pop_front();
				n_checked++;
				if (act.position !== exp_out.position || act.accepted !== exp_out.accepted ||
					act.ready !== exp_out.ready || act.mask !== exp_out.mask) begin
					errors++;
					if (errors <= 10)
						$display("%0t item %0d: expected pos %0d acc %0b rdy %0b mask %05b, got pos %0d acc %0b rdy %0b mask %05b",
							$realtime, n_checked, exp_out.position, exp_out.accepted,
							exp_out.ready, exp_out.mask, act.position, act.accepted,
							act.ready, act.mask);
				end
			end
		end
	end

endmodule

// File: files.f
+incdir+hdl
hdl/plc_pkg.sv
hdl/plc_point_store.sv
hdl/plc_serial_muldiv.sv
hdl/piecewise_linear_calibration.sv
test/piecewise_linear_calibration_test.sv
